FILE: rtl/rgbhsv_pkg.sv
package rgbhsv_pkg;

   // fixed point scaling
   localparam int FRAC_BITS = 6;
   localparam int UNIT      = 1 << FRAC_BITS;

   // channel and result widths
   localparam int CH_W   = 8;
   localparam int CH_MAX = (1 << CH_W) - 1;
   localparam int HUE_W  = 15;
   localparam int PCT_W  = 13;

   // hue and percent scales
   localparam int HUE_SCALE = 60 * UNIT;
   localparam int PCT_SCALE = 100 * UNIT;
   localparam int HUE_GREEN = 120 * UNIT;
   localparam int HUE_BLUE  = 240 * UNIT;
   localparam int HUE_WRAP  = 360 * UNIT;

   // divider sizing: quotient never exceeds PCT_SCALE
   localparam int NUM_W = $clog2(CH_MAX * PCT_SCALE + 1);
   localparam int QUO_W = $clog2(PCT_SCALE + 1);
   localparam int LANES = 2;
   localparam int LANE_HUE = 0;
   localparam int LANE_SAT = 1;

   // brightness = mx * BRI_WHOLE + floor(mx * BRI_REST / CH_MAX)
   localparam int BRI_WHOLE = PCT_SCALE / CH_MAX;
   localparam int BRI_REST  = PCT_SCALE % CH_MAX;
   localparam int BRI_T_W   = 2 * CH_W;

   typedef enum logic [1:0] {
      SECT_RED,
      SECT_GREEN,
      SECT_BLUE
   } sector_type;

   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [CH_W-1:0]  den;
      logic [CH_W-1:0]  rem;
      logic [QUO_W-1:0] quo;
   } lane_type;

   typedef lane_type [LANES-1:0] lanes_type;

   typedef struct packed {
      sector_type         sector;
      logic               neg;
      logic               grey;
      logic               black;
      logic [PCT_W-1:0]   bri_base;
      logic [BRI_T_W-1:0] bri_t;
   } side_type;

endpackage

FILE: rtl/rgbhsv_if.sv
interface rgbhsv_req_if;
   logic                        valid;
   logic                        ready;
   logic [rgbhsv_pkg::CH_W-1:0] red;
   logic [rgbhsv_pkg::CH_W-1:0] green;
   logic [rgbhsv_pkg::CH_W-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rgbhsv_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [rgbhsv_pkg::HUE_W-1:0] hue_deg;
   logic [rgbhsv_pkg::PCT_W-1:0] sat_pct;
   logic [rgbhsv_pkg::PCT_W-1:0] bright_pct;

   modport source (output valid, output hue_deg, output sat_pct, output bright_pct,
                   input ready);
   modport sink   (input valid, input hue_deg, input sat_pct, input bright_pct,
                   output ready);
endinterface

FILE: rtl/rgbhsv_div.sv
module rgbhsv_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  rgbhsv_pkg::lanes_type in_lanes,
   input  rgbhsv_pkg::side_type  in_side,
   output logic                  out_valid,
   input  logic                  out_ready,
   output rgbhsv_pkg::lanes_type out_lanes,
   output rgbhsv_pkg::side_type  out_side
);

   localparam int STAGES = rgbhsv_pkg::QUO_W;

   logic                  valid_ff [STAGES];
   rgbhsv_pkg::lanes_type lanes_ff [STAGES];
   rgbhsv_pkg::side_type  side_ff  [STAGES];
   logic                  stage_ready [STAGES];

   // a stage takes new data when empty or when the one after it moves
   always_comb begin
      for (int s = STAGES - 1; s >= 0; s--) begin
         if (s == STAGES - 1) begin
            stage_ready[s] = !valid_ff[s] || out_ready;
         end else begin
            stage_ready[s] = !valid_ff[s] || stage_ready[s+1];
         end
      end
   end

   genvar st;
   generate
      for (st = 0; st < STAGES; st++) begin : g_stage
         localparam int BIT = STAGES - 1 - st;

         rgbhsv_pkg::lanes_type src_lanes;
         rgbhsv_pkg::side_type  src_side;
         logic                  src_valid;
         rgbhsv_pkg::lanes_type step_in;

         if (st == 0) begin : g_first
            assign src_lanes = in_lanes;
            assign src_side  = in_side;
            assign src_valid = in_valid;
         end else begin : g_next
            assign src_lanes = lanes_ff[st-1];
            assign src_side  = side_ff[st-1];
            assign src_valid = valid_ff[st-1];
         end

         // one restoring quotient bit per lane
         always_comb begin
            logic [rgbhsv_pkg::CH_W:0] trial;
            step_in = src_lanes;
            for (int l = 0; l < rgbhsv_pkg::LANES; l++) begin
               trial = {src_lanes[l].rem, src_lanes[l].num[BIT]};
               if (trial >= {1'b0, src_lanes[l].den}) begin
                  step_in[l].rem      = rgbhsv_pkg::CH_W'(trial - {1'b0, src_lanes[l].den});
                  step_in[l].quo[BIT] = 1'b1;
               end else begin
                  step_in[l].rem      = trial[rgbhsv_pkg::CH_W-1:0];
                  step_in[l].quo[BIT] = 1'b0;
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[st] <= 1'b0;
            end else if (stage_ready[st]) begin
               valid_ff[st] <= src_valid;
            end
            if (stage_ready[st]) begin
               lanes_ff[st] <= step_in;
               side_ff[st]  <= src_side;
            end
         end
      end
   endgenerate

   assign in_ready  = stage_ready[0];
   assign out_valid = valid_ff[STAGES-1];
   assign out_lanes = lanes_ff[STAGES-1];
   assign out_side  = side_ff[STAGES-1];

endmodule

FILE: rtl/rgb_to_hsv_convert.sv
// RGB to HSV converter for pixel streams. Takes one 8-bit RGB pixel per clock while the
// result side does not stall, and returns hue in degrees times 64 (0 to 23039),
// saturation and brightness in percent times 64 (0 to 6400). A front register holds
// max/min and sector selection, then a pipelined restoring divider resolves one quotient
// bit per stage for hue and saturation side by side, and hue assembly feeds the output
// register. Stalls on the result side back up through the stages, and empty stages keep
// taking pixels until the pipeline is full.
module rgb_to_hsv_convert (
   input logic         clock,
   input logic         reset,
   rgbhsv_req_if.sink  req_chan,
   rgbhsv_rsp_if.source rsp_chan
);

   // front stage: channel max/min and hue sector
   logic                              a_valid_ff;
   rgbhsv_pkg::sector_type            a_sector_ff;
   logic                              a_neg_ff;
   logic [rgbhsv_pkg::CH_W-1:0]       a_absdiff_ff;
   logic [rgbhsv_pkg::CH_W-1:0]       a_delta_ff;
   logic [rgbhsv_pkg::CH_W-1:0]       a_max_ff;

   rgbhsv_pkg::sector_type            a_sector_in;
   logic                              a_neg_in;
   logic [rgbhsv_pkg::CH_W-1:0]       a_absdiff_in;
   logic [rgbhsv_pkg::CH_W-1:0]       a_delta_in;
   logic [rgbhsv_pkg::CH_W-1:0]       a_max_in;
   logic                              a_ready;

   logic                              div_in_ready;
   rgbhsv_pkg::lanes_type             div_in_lanes;
   rgbhsv_pkg::side_type              div_in_side;
   logic                              div_out_valid;
   logic                              div_out_ready;
   rgbhsv_pkg::lanes_type             div_out_lanes;
   rgbhsv_pkg::side_type              div_out_side;

   logic                              out_valid_ff;
   logic [rgbhsv_pkg::HUE_W-1:0]      hue_ff;
   logic [rgbhsv_pkg::PCT_W-1:0]      sat_ff;
   logic [rgbhsv_pkg::PCT_W-1:0]      bri_ff;
   logic [rgbhsv_pkg::HUE_W-1:0]      hue_in;
   logic [rgbhsv_pkg::PCT_W-1:0]      sat_in;
   logic [rgbhsv_pkg::PCT_W-1:0]      bri_in;

   always_comb begin
      logic [rgbhsv_pkg::CH_W-1:0] r;
      logic [rgbhsv_pkg::CH_W-1:0] g;
      logic [rgbhsv_pkg::CH_W-1:0] b;
      logic [rgbhsv_pkg::CH_W-1:0] mn;
      logic [rgbhsv_pkg::CH_W-1:0] minu;
      logic [rgbhsv_pkg::CH_W-1:0] subt;
      r = req_chan.red;
      g = req_chan.green;
      b = req_chan.blue;
      // ties go to red, then green
      if (r >= g && r >= b) begin
         a_sector_in = rgbhsv_pkg::SECT_RED;
         a_max_in    = r;
         minu        = g;
         subt        = b;
      end else if (g >= b) begin
         a_sector_in = rgbhsv_pkg::SECT_GREEN;
         a_max_in    = g;
         minu        = b;
         subt        = r;
      end else begin
         a_sector_in = rgbhsv_pkg::SECT_BLUE;
         a_max_in    = b;
         minu        = r;
         subt        = g;
      end
      mn = r;
      if (g < mn) begin
         mn = g;
      end
      if (b < mn) begin
         mn = b;
      end
      a_delta_in   = a_max_in - mn;
      a_neg_in     = minu < subt;
      a_absdiff_in = a_neg_in ? (subt - minu) : (minu - subt);
   end

   assign a_ready        = !a_valid_ff || div_in_ready;
   assign req_chan.ready = a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= req_chan.valid;
      end
      if (a_ready) begin
         a_sector_ff  <= a_sector_in;
         a_neg_ff     <= a_neg_in;
         a_absdiff_ff <= a_absdiff_in;
         a_delta_ff   <= a_delta_in;
         a_max_ff     <= a_max_in;
      end
   end

   // divider operands: |diff| * 60 * unit over delta, delta * 100 * unit over max
   always_comb begin
      logic [rgbhsv_pkg::NUM_W-1:0] hue_num;
      logic [rgbhsv_pkg::NUM_W-1:0] sat_num;
      hue_num = rgbhsv_pkg::NUM_W'(a_absdiff_ff) * rgbhsv_pkg::NUM_W'(rgbhsv_pkg::HUE_SCALE);
      sat_num = rgbhsv_pkg::NUM_W'(a_delta_ff) * rgbhsv_pkg::NUM_W'(rgbhsv_pkg::PCT_SCALE);

      div_in_lanes[rgbhsv_pkg::LANE_HUE].num = hue_num;
      div_in_lanes[rgbhsv_pkg::LANE_HUE].den = a_delta_ff;
      div_in_lanes[rgbhsv_pkg::LANE_HUE].rem =
         hue_num[rgbhsv_pkg::NUM_W-1:rgbhsv_pkg::QUO_W];
      div_in_lanes[rgbhsv_pkg::LANE_HUE].quo = '0;

      div_in_lanes[rgbhsv_pkg::LANE_SAT].num = sat_num;
      div_in_lanes[rgbhsv_pkg::LANE_SAT].den = a_max_ff;
      div_in_lanes[rgbhsv_pkg::LANE_SAT].rem =
         sat_num[rgbhsv_pkg::NUM_W-1:rgbhsv_pkg::QUO_W];
      div_in_lanes[rgbhsv_pkg::LANE_SAT].quo = '0;

      div_in_side.sector   = a_sector_ff;
      div_in_side.neg      = a_neg_ff;
      div_in_side.grey     = (a_delta_ff == '0);
      div_in_side.black    = (a_max_ff == '0);
      div_in_side.bri_base = rgbhsv_pkg::PCT_W'(a_max_ff) *
                             rgbhsv_pkg::PCT_W'(rgbhsv_pkg::BRI_WHOLE);
      div_in_side.bri_t    = rgbhsv_pkg::BRI_T_W'(a_max_ff) *
                             rgbhsv_pkg::BRI_T_W'(rgbhsv_pkg::BRI_REST);
   end

   rgbhsv_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (a_valid_ff),
      .in_ready  (div_in_ready),
      .in_lanes  (div_in_lanes),
      .in_side   (div_in_side),
      .out_valid (div_out_valid),
      .out_ready (div_out_ready),
      .out_lanes (div_out_lanes),
      .out_side  (div_out_side)
   );

   // hue assembly and brightness correction
   always_comb begin
      logic [rgbhsv_pkg::QUO_W-1:0]   q;
      logic [rgbhsv_pkg::QUO_W-1:0]   qc;
      logic [rgbhsv_pkg::HUE_W:0]     h;
      logic [rgbhsv_pkg::CH_W:0]      bq;
      logic [rgbhsv_pkg::CH_W:0]      br;
      q  = div_out_lanes[rgbhsv_pkg::LANE_HUE].quo;
      // ceiling of the magnitude gives floor of the negative quotient
      qc = q + rgbhsv_pkg::QUO_W'(div_out_lanes[rgbhsv_pkg::LANE_HUE].rem != '0);
      case (div_out_side.sector)
         rgbhsv_pkg::SECT_RED: begin
            if (!div_out_side.neg) begin
               h = (rgbhsv_pkg::HUE_W + 1)'(q);
            end else if (qc == '0) begin
               h = '0;
            end else begin
               h = (rgbhsv_pkg::HUE_W + 1)'(rgbhsv_pkg::HUE_WRAP) -
                   (rgbhsv_pkg::HUE_W + 1)'(qc);
            end
         end
         rgbhsv_pkg::SECT_GREEN: begin
            if (div_out_side.neg) begin
               h = (rgbhsv_pkg::HUE_W + 1)'(rgbhsv_pkg::HUE_GREEN) -
                   (rgbhsv_pkg::HUE_W + 1)'(qc);
            end else begin
               h = (rgbhsv_pkg::HUE_W + 1)'(rgbhsv_pkg::HUE_GREEN) +
                   (rgbhsv_pkg::HUE_W + 1)'(q);
            end
         end
         rgbhsv_pkg::SECT_BLUE: begin
            if (div_out_side.neg) begin
               h = (rgbhsv_pkg::HUE_W + 1)'(rgbhsv_pkg::HUE_BLUE) -
                   (rgbhsv_pkg::HUE_W + 1)'(qc);
            end else begin
               h = (rgbhsv_pkg::HUE_W + 1)'(rgbhsv_pkg::HUE_BLUE) +
                   (rgbhsv_pkg::HUE_W + 1)'(q);
            end
         end
         default: begin
            h = '0;
         end
      endcase
      hue_in = div_out_side.grey ? '0 : h[rgbhsv_pkg::HUE_W-1:0];

      sat_in = div_out_side.black ? '0 :
               rgbhsv_pkg::PCT_W'(div_out_lanes[rgbhsv_pkg::LANE_SAT].quo);

      // divide by 2^n - 1: shift estimate plus one correction step
      bq = (rgbhsv_pkg::CH_W + 1)'(div_out_side.bri_t >> rgbhsv_pkg::CH_W);
      br = (rgbhsv_pkg::CH_W + 1)'(div_out_side.bri_t[rgbhsv_pkg::CH_W-1:0]) + bq;
      if (br >= (rgbhsv_pkg::CH_W + 1)'(rgbhsv_pkg::CH_MAX)) begin
         bq = bq + (rgbhsv_pkg::CH_W + 1)'(1);
      end
      bri_in = div_out_side.bri_base + rgbhsv_pkg::PCT_W'(bq);
   end

   assign div_out_ready = !out_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (div_out_ready) begin
         out_valid_ff <= div_out_valid;
      end
      if (div_out_ready) begin
         hue_ff <= hue_in;
         sat_ff <= sat_in;
         bri_ff <= bri_in;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.hue_deg    = hue_ff;
   assign rsp_chan.sat_pct    = sat_ff;
   assign rsp_chan.bright_pct = bri_ff;

   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (hue_ff < rgbhsv_pkg::HUE_W'(rgbhsv_pkg::HUE_WRAP)))
      else $error("hue out of range");

   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (sat_ff <= rgbhsv_pkg::PCT_W'(rgbhsv_pkg::PCT_SCALE) &&
                        bri_ff <= rgbhsv_pkg::PCT_W'(rgbhsv_pkg::PCT_SCALE)))
      else $error("percent out of range");

   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && sat_ff == '0) |-> (hue_ff == '0))
      else $error("grey pixel with nonzero hue");

   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && sat_ff != '0) |-> (bri_ff != '0))
      else $error("saturated pixel with zero brightness");

endmodule
